### rtl/bae_pkg.sv
// ----------------------------------------------------------------------------
// bae_pkg
// Shared types and constants for the binary arithmetic encoder.
// ----------------------------------------------------------------------------
package bae_pkg;

    // Default depth of the command queue between the front and the core
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [31:0] LOW_RESET  = 32'h0000_0000;
    localparam logic [31:0] HIGH_RESET = 32'hffff_ffff;
    localparam logic [31:0] TOP_MASK   = 32'hff00_0000;
    localparam logic [7:0]  FILL_BYTE  = 8'hff;

    // Shift count of the fourth (final permitted) byte of one encode
    localparam logic [1:0]  LAST_SHIFT = 2'd3;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_FLUSH  = 1'b1
    } op_t;

    typedef struct packed {
        op_t         op;
        logic        bit_value;
        logic [15:0] probability;
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic full;
    } queue_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_EMIT,
        ST_FLUSH
    } core_state_t;

    typedef struct packed {
        logic busy;
        logic top_differ;
        logic ordered;
    } core_status_t;

endpackage

### rtl/bae_front.sv
// ----------------------------------------------------------------------------
// bae_front
// Input side: unpacks and classifies transactions into a small command queue.
// ----------------------------------------------------------------------------
module bae_front #(
    parameter int DEPTH = bae_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // [0] bit_value, [16:1] probability
    input  logic [0:0]            s_tuser,   // [0] operation
    input  logic                  pop,
    output bae_pkg::cmd_t         head,
    output bae_pkg::queue_status_t q_status
);
    import bae_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    cmd_t             in_cmd;
    logic             push;

    // classify the incoming transaction
    always_comb begin
        in_cmd.op          = op_t'(s_tuser[0]);
        in_cmd.bit_value   = s_tdata[0];
        in_cmd.probability = s_tdata[16:1];
    end

    assign s_tready = (count_reg != CNT_W'(DEPTH));
    assign push     = s_tvalid && s_tready;

    assign head           = entry_reg[rd_ptr_reg];
    assign q_status.valid = (count_reg != '0);
    assign q_status.full  = !s_tready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

### rtl/bae_core.sv
// ----------------------------------------------------------------------------
// bae_core
// Back end: interval update, byte renormalisation and output register.
// ----------------------------------------------------------------------------
module bae_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bae_pkg::cmd_t        head,
    input  logic                 head_valid,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,
    output logic                 m_tlast,
    output bae_pkg::core_status_t status
);
    import bae_pkg::*;

    core_state_t state_reg, state_next;
    logic [31:0] low_reg, low_next;
    logic [31:0] high_reg, high_next;
    logic [31:0] hi_prod_reg, hi_prod_next;
    logic [15:0] lo_prod_reg, lo_prod_next;
    logic        bit_reg, bit_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [7:0]  out_data_reg, out_data_next;
    logic        out_last_reg, out_last_next;
    logic        out_valid_reg, out_valid_next;

    logic [31:0] range_w, hi_prod_w, lo_prod_w;
    logic [31:0] split_w, split_inc_w, upd_low_w, upd_high_w;
    logic [31:0] shl_low_w, shl_high_w;
    logic        upd_equal_w, shl_differ_w, emit_last_w, out_free_w, load_w;

    // partial products of range * p / 65536 (16 x 16 bits each)
    assign range_w   = high_reg - low_reg;
    assign hi_prod_w = {16'b0, range_w[31:16]} * {16'b0, head.probability};
    assign lo_prod_w = {16'b0, range_w[15:0]} * {16'b0, head.probability};

    assign split_w     = low_reg + hi_prod_reg + {16'b0, lo_prod_reg};
    assign split_inc_w = split_w + 32'd1;
    assign upd_low_w   = bit_reg ? low_reg : split_inc_w;
    assign upd_high_w  = bit_reg ? split_w : high_reg;
    assign upd_equal_w = ((upd_low_w ^ upd_high_w) & TOP_MASK) == '0;

    assign shl_low_w    = {low_reg[23:0], 8'h00};
    assign shl_high_w   = {high_reg[23:0], FILL_BYTE};
    assign shl_differ_w = ((shl_low_w ^ shl_high_w) & TOP_MASK) != '0;
    assign emit_last_w  = (cnt_reg == LAST_SHIFT) || shl_differ_w;

    assign out_free_w = !out_valid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (head_valid) begin
                    state_next = (head.op == OP_FLUSH) ? ST_FLUSH : ST_ADD;
                end
            end
            ST_ADD: begin
                state_next = upd_equal_w ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (out_free_w && emit_last_w) begin
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (out_free_w) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        pop           = 1'b0;
        load_w        = 1'b0;
        low_next      = low_reg;
        high_next     = high_reg;
        hi_prod_next  = hi_prod_reg;
        lo_prod_next  = lo_prod_reg;
        bit_next      = bit_reg;
        cnt_next      = cnt_reg;
        out_data_next = out_data_reg;
        out_last_next = out_last_reg;
        case (state_reg)
            ST_IDLE: begin
                if (head_valid) begin
                    pop          = 1'b1;
                    hi_prod_next = hi_prod_w;
                    lo_prod_next = lo_prod_w[31:16];
                    bit_next     = head.bit_value;
                end
            end
            ST_ADD: begin
                low_next  = upd_low_w;
                high_next = upd_high_w;
                cnt_next  = '0;
            end
            ST_EMIT: begin
                if (out_free_w) begin
                    load_w        = 1'b1;
                    out_data_next = high_reg[31:24];
                    out_last_next = emit_last_w;
                    low_next      = shl_low_w;
                    high_next     = shl_high_w;
                    cnt_next      = cnt_reg + 1'b1;
                end
            end
            ST_FLUSH: begin
                if (out_free_w) begin
                    load_w        = 1'b1;
                    out_data_next = high_reg[31:24];
                    out_last_next = 1'b1;
                end
            end
            default: begin
                pop = 1'b0;
            end
        endcase
        out_valid_next = load_w ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            low_reg       <= LOW_RESET;
            high_reg      <= HIGH_RESET;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hi_prod_reg  <= hi_prod_next;
        lo_prod_reg  <= lo_prod_next;
        bit_reg      <= bit_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    assign status.busy       = (state_reg != ST_IDLE);
    assign status.top_differ = ((low_reg ^ high_reg) & TOP_MASK) != '0;
    assign status.ordered    = (low_reg <= high_reg);

endmodule

### rtl/binary_arithmetic_encoder_unit.sv
// ----------------------------------------------------------------------------
// binary_arithmetic_encoder_unit
// Carry-less 32-bit binary arithmetic encoder with stream interfaces.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave channel: one transaction per command. tuser[0] selects encode (0)
//    or flush (1); tdata carries the bit to encode and a 16-bit probability
//    of a one. Commands enter a small queue (QUEUE_DEPTH entries) so the
//    sender is not held while the core renormalises.
//  - Master channel: one byte of the compressed stream per transaction;
//    tlast marks the final byte produced by a given command. An encode gives
//    zero to four bytes, a flush exactly one (top byte of the high bound,
//    bounds unchanged).
//  - Timing: an encode passes through the core in IDLE (partial products
//    from the queue head), then ADD (three-way add and bound update), then
//    EMIT once per emitted byte. A flush passes through IDLE and FLUSH.
//    The bound update loop sets the rate.
//  - Reset (aresetn low, synchronous): queue emptied, low bound 0, high
//    bound all ones, output register empty.
//  - Receiver stall: the output register holds its byte; the core waits,
//    the queue fills, then s_tready drops.
// ----------------------------------------------------------------------------
module binary_arithmetic_encoder_unit #(
    parameter int QUEUE_DEPTH = bae_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [0] bit_value, [16:1] probability, [23:17] zero
    input  logic [0:0]  s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast    // last_of_run
);
    import bae_pkg::*;

    cmd_t          head;
    queue_status_t q_status;
    core_status_t  c_status;
    logic          pop;

    // front end: unpack and queue commands
    bae_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .pop      (pop),
        .head     (head),
        .q_status (q_status)
    );

    // back end: interval arithmetic and byte output
    bae_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .head_valid (q_status.valid),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .status     (c_status)
    );

    // Between commands the interval must be separated in its top byte,
    // otherwise renormalisation stopped early.
    a_idle_separated: assert property (@(posedge aclk) disable iff (!aresetn)
        !c_status.busy |-> c_status.top_differ)
        else $error("bounds share top byte while core idle");

    a_idle_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        !c_status.busy |-> c_status.ordered)
        else $error("low bound above high bound");

    // A full queue always presents a command to the core
    a_full_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.full |-> q_status.valid)
        else $error("queue full but head not valid");

    // A command is only taken when the queue has one
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_status.valid)
        else $error("pop from empty queue");

endmodule
